/* hdl/ffba_pkg.sv */
// shared types and constants for the first-fit bin allocator
`timescale 1ns / 1ps

package ffba_pkg;

  // number of bins and field widths
  localparam int MAX_BINS    = 5;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);

  // result field widths fixed by the interface
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 3;
  localparam int OUT_CNT_W = 3;

  // capacity after reset
  localparam logic [WEIGHT_BITS-1:0] CAP_RESET = WEIGHT_BITS'(40000);

  typedef logic [WEIGHT_BITS-1:0] weight_t;

  // outcome of one item
  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 2'd0,
    ST_OPENED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  // decision for one item, from the pick logic to the bin bank
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] idx;
    weight_t          left;
    logic [CNT_W-1:0] cnt_after;
  } pick_t;

endpackage

/* hdl/first_fit_bin_allocator.sv */
// top level: input register, first-fit bin bank, result register
//
//   channel  direction  handshake              payload
//   in_      to block   in_valid / in_stall    in_item_weight, in_last_item
//   out_     from block out_valid / out_stall  out_status, out_bin_index, out_bin_left,
//                                              out_bins_in_use, out_list_done
//   cfg_     to block   cfg_wr_en              cfg_wr_data (bin capacity)
//
// one item per cycle while the result is not stalled; an accepted item is held in the input register
// and moves on into the result register, where its result shows.
// the loop from the bin remainders through the compare, pick and subtract back to
// the remainders sets the one-cycle item rate.
// synchronous active-low reset empties all bins and sets the capacity to 40000.
// a stalled result holds both registers; in_stall rises only while both are full.
`timescale 1ns / 1ps

module first_fit_bin_allocator
  import ffba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WEIGHT_BITS-1:0] in_item_weight,
  input  logic                   in_last_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_IDX_W-1:0]   out_bin_index,
  output logic [WEIGHT_BITS-1:0] out_bin_left,
  output logic [OUT_CNT_W-1:0]   out_bins_in_use,
  output logic                   out_list_done,
  input  logic                   cfg_wr_en,
  input  logic [WEIGHT_BITS-1:0] cfg_wr_data
);

  weight_t capacity_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  weight_t s1_weight_r;
  logic    s1_last_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  status_t out_status_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  weight_t              out_left_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic                 out_last_r;
  logic    adv;
  logic    accept;
  logic    step;
  pick_t   pick;

  // pipeline moves when the result register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign step     = s1_valid_r && adv;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  ffba_bin_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .weight   (s1_weight_r),
    .last     (s1_last_r),
    .capacity (capacity_r),
    .pick     (pick)
  );

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_weight_r <= in_item_weight;
      s1_last_r   <= in_last_item;
    end
  end

  // result register
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_status_r <= pick.status;
      out_idx_r    <= OUT_IDX_W'(pick.idx);
      out_left_r   <= pick.left;
      out_cnt_r    <= OUT_CNT_W'(pick.cnt_after);
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bin_index   = out_idx_r;
  assign out_bin_left    = out_left_r;
  assign out_bins_in_use = out_cnt_r;
  assign out_list_done   = out_last_r;

`ifndef ASSERT_OFF
  // a rejected item names no bin and no remainder
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status_r == ST_FULL) || (out_status_r == ST_OVERSIZE))
    |-> (out_bin_index == '0) && (out_bin_left == '0))
    else $error("rejected item carries a bin");

  // a newly opened bin is the highest open one
  a_open_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_r == ST_OPENED)
    |-> (out_bin_index == out_bins_in_use - OUT_CNT_W'(1)))
    else $error("opened bin is not the newest");

  // a placed item lands in an open bin
  a_place_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_r == ST_PLACED) |-> (out_bin_index < out_bins_in_use))
    else $error("item placed in a closed bin");

  // a no-free-bin result only with every bin open
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_r == ST_FULL) |-> (out_bins_in_use == OUT_CNT_W'(MAX_BINS)))
    else $error("full result with a bin still free");

  // a held item stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_weight_r))
    else $error("held item lost");
`endif

endmodule

/* hdl/ffba_bin_pick.sv */
// first-fit search over the open bins and the new remainder
`timescale 1ns / 1ps

module ffba_bin_pick
  import ffba_pkg::*;
(
  input  weight_t                   weight,
  input  weight_t                   capacity,
  input  logic [CNT_W-1:0]          open_cnt,
  input  weight_t [MAX_BINS-1:0]    space,
  output pick_t                     pick
);

  logic [MAX_BINS-1:0] fit;
  logic [IDX_W-1:0]    first_idx;
  logic                found;

  // one compare per bin, only open bins count
  always_comb begin
    for (int j = 0; j < MAX_BINS; j++) begin
      fit[j] = (CNT_W'(j) < open_cnt) && (space[j] >= weight);
    end
  end

  // lowest fitting bin wins
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int j = MAX_BINS - 1; j >= 0; j--) begin
      if (fit[j]) begin
        found     = 1'b1;
        first_idx = IDX_W'(j);
      end
    end
  end

  // decision and remainder
  always_comb begin
    pick.status    = ST_FULL;
    pick.idx       = '0;
    pick.left      = '0;
    pick.cnt_after = open_cnt;
    priority if (weight > capacity) begin
      pick.status = ST_OVERSIZE;
    end else if (found) begin
      pick.status = ST_PLACED;
      pick.idx    = first_idx;
      pick.left   = space[first_idx] - weight;
    end else if (open_cnt < CNT_W'(MAX_BINS)) begin
      pick.status    = ST_OPENED;
      pick.idx       = open_cnt[IDX_W-1:0];
      pick.left      = capacity - weight;
      pick.cnt_after = open_cnt + CNT_W'(1);
    end else begin
      pick.status = ST_FULL;
    end
  end

endmodule

/* hdl/ffba_bin_bank.sv */
// bin remainders and open count, updated once per item
`timescale 1ns / 1ps

module ffba_bin_bank
  import ffba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  weight_t weight,
  input  logic    last,
  input  weight_t capacity,
  output pick_t   pick
);

  weight_t [MAX_BINS-1:0] space_r;
  logic [CNT_W-1:0]       open_cnt_r;
  logic [CNT_W-1:0]       open_cnt_nxt;
  logic                   wr_en;

  ffba_bin_pick u_pick (
    .weight   (weight),
    .capacity (capacity),
    .open_cnt (open_cnt_r),
    .space    (space_r),
    .pick     (pick)
  );

  // a placed or opened item writes its bin
  assign wr_en = step && ((pick.status == ST_PLACED) || (pick.status == ST_OPENED));

  // last item of a list empties the bank
  always_comb begin
    open_cnt_nxt = open_cnt_r;
    if (step) begin
      open_cnt_nxt = last ? '0 : pick.cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cnt_r <= '0;
    end else begin
      open_cnt_r <= open_cnt_nxt;
    end
  end

  // remainders only read below the open count, no reset
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_BINS; j++) begin
      if (wr_en && (pick.idx == IDX_W'(j))) begin
        space_r[j] <= pick.left;
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench for the first-fit bin allocator: bin predictor, item driver, result monitor
`timescale 1ns / 1ps

module tb_top;
  import ffba_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    weight_t weight;
    logic    last;
  } alloc_req_t;

  typedef struct {
    status_t              status;
    logic [OUT_IDX_W-1:0] bin;
    weight_t              left;
    logic [OUT_CNT_W-1:0] used;
    logic                 done;
  } alloc_res_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  weight_t              in_item_weight = '0;
  logic                 in_last_item   = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [OUT_IDX_W-1:0] out_bin_index;
  weight_t              out_bin_left;
  logic [OUT_CNT_W-1:0] out_bins_in_use;
  logic                 out_list_done;
  logic                 cfg_wr_en      = 1'b0;
  weight_t              cfg_wr_data    = '0;

  // bin state as the predictor tracks it
  weight_t     capacity_now = CAP_RESET;
  int unsigned bins_open    = 0;
  weight_t     room [MAX_BINS];

  alloc_req_t  pending_items [$];
  alloc_res_t  expected_results [$];
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned cycle_count   = 0;

  first_fit_bin_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item_weight  (in_item_weight),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_bin_index   (out_bin_index),
    .out_bin_left    (out_bin_left),
    .out_bins_in_use (out_bins_in_use),
    .out_list_done   (out_list_done),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // 4 ns clock
  always #2 clk = ~clk;

  // first-fit placement of one item, updates the tracked bins
  function automatic alloc_res_t place_weight(weight_t w, logic last);
    alloc_res_t r;
    bit         found;
    found    = 1'b0;
    r.status = ST_FULL;
    r.bin    = '0;
    r.left   = '0;
    r.done   = last;
    if (w > capacity_now) begin
      r.status = ST_OVERSIZE;
    end else begin
      for (int j = 0; j < bins_open; j++) begin
        if (!found && room[j] >= w) begin
          room[j]  = room[j] - w;
          r.status = ST_PLACED;
          r.bin    = OUT_IDX_W'(j);
          r.left   = room[j];
          found    = 1'b1;
        end
      end
      // nothing fits: open the next bin if one is left
      if (!found && bins_open < MAX_BINS) begin
        room[bins_open] = capacity_now - w;
        r.status        = ST_OPENED;
        r.bin           = OUT_IDX_W'(bins_open);
        r.left          = room[bins_open];
        bins_open++;
      end
    end
    r.used = OUT_CNT_W'(bins_open);
    // end of list empties every bin
    if (last) begin
      bins_open = 0;
      foreach (room[k]) room[k] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // driver: offers the next pending item and predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(place_weight(in_item_weight, in_last_item));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid       <= 1'b1;
          in_item_weight <= pending_items[0].weight;
          in_last_item   <= pending_items[0].last;
          pending_items.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    alloc_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting, status %0d bin %0d",
                                    out_status, out_bin_index));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
          if (out_bin_index !== want.bin)
            report_mismatch($sformatf("bin_index got %0d expected %0d",
                                      out_bin_index, want.bin));
          if (out_bin_left !== want.left)
            report_mismatch($sformatf("bin_left got %0d expected %0d",
                                      out_bin_left, want.left));
          if (out_bins_in_use !== want.used)
            report_mismatch($sformatf("bins_in_use got %0d expected %0d",
                                      out_bins_in_use, want.used));
          if (out_list_done !== want.done)
            report_mismatch($sformatf("list_done got %0d expected %0d",
                                      out_list_done, want.done));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic queue_item(weight_t w, logic last);
    alloc_req_t req;
    req.weight = w;
    req.last   = last;
    pending_items.push_back(req);
  endtask

  // block idle: every item sent and every result back
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(int unsigned cap);
    wait_idle();
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= weight_t'(cap);
    capacity_now  = weight_t'(cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // weights spread around the current capacity
  function automatic weight_t pick_weight();
    int unsigned cap;
    cap = capacity_now;
    case ($urandom_range(11))
      0:       return '0;
      1:       return capacity_now;
      2:       return (cap == 65535) ? weight_t'(cap) : weight_t'($urandom_range(65535, cap + 1));
      3:       return weight_t'($urandom);
      4, 5, 6: return weight_t'($urandom_range(cap / 4));
      7, 8:    return weight_t'($urandom_range(cap / 2));
      default: return weight_t'($urandom_range(cap, cap / 2));
    endcase
  endfunction

  // mostly complete lists, some loose items with random end marks
  task automatic random_phase(int unsigned cap, int send_pct, int stall_p, int n_items);
    int made;
    int len;
    made = 0;
    set_capacity(cap);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
    while (made < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(14, 1);
        for (int k = 0; k < len; k++) queue_item(pick_weight(), k == len - 1);
      end else begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++) queue_item(weight_t'($urandom), $urandom_range(1) == 1);
      end
      made += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: exact fit, oversize, filling all bins, full, zero weight
    queue_item(16'd0, 1'b0);
    queue_item(16'd40000, 1'b0);
    queue_item(16'd40001, 1'b0);
    queue_item(16'd65535, 1'b0);
    queue_item(16'd30000, 1'b0);
    queue_item(16'd10000, 1'b0);
    queue_item(16'd20000, 1'b0);
    queue_item(16'd20000, 1'b0);
    queue_item(16'd20000, 1'b0);
    queue_item(16'd25000, 1'b0);
    queue_item(16'd30000, 1'b0);
    queue_item(16'd0, 1'b0);
    queue_item(16'd15000, 1'b1);

    // zero capacity, list left open
    set_capacity(0);
    queue_item(16'd0, 1'b0);
    queue_item(16'd1, 1'b0);
    queue_item(16'd0, 1'b0);

    // full capacity on top of open bins
    set_capacity(65535);
    queue_item(16'd65535, 1'b0);
    queue_item(16'd100, 1'b0);

    // capacity shrinks mid-list: oversize even though an open bin has room
    set_capacity(50);
    queue_item(16'd60, 1'b0);
    queue_item(16'd50, 1'b0);
    queue_item(16'd30, 1'b1);

    random_phase(65535, 0, 0, 280);
    random_phase(1000, 71, 0, 280);
    random_phase($urandom_range(65535), 0, 71, 280);
    random_phase(40000, 19, 19, 280);
    random_phase(12, 0, 0, 280);
    random_phase(0, 0, 71, 60);

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
